>>> hw/rtl/rbes_pkg.sv
`timescale 1ns / 1ps

package rbes_pkg;

    // Sizes of the body table and the fixed point format.
    localparam int NUM_BODIES = 64;
    localparam int BODY_W     = 6;
    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int DT_W       = 18;
    localparam int DRAG_W     = 17;
    localparam int INV_W      = 31;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP   = 2'd0,
        CFG_GRAVITY_Y   = 2'd1,
        CFG_DRAG_AIR    = 2'd2,
        CFG_DRAG_GROUND = 2'd3
    } cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [DT_W-1:0]          TIME_STEP_RST   = 18'd1092;
    localparam logic signed [WORD_W-1:0] GRAVITY_Y_RST   = -32'sd642253;
    localparam logic [DRAG_W-1:0]        DRAG_AIR_RST    = 17'd65427;
    localparam logic [DRAG_W-1:0]        DRAG_GROUND_RST = 17'd65318;

    typedef logic [2:0][WORD_W-1:0] vec3_t;

    typedef struct packed {
        logic [DT_W-1:0]          time_step;
        logic signed [WORD_W-1:0] gravity_y;
        logic [DRAG_W-1:0]        drag_air;
        logic [DRAG_W-1:0]        drag_ground;
    } cfg_t;

    typedef struct packed {
        logic [BODY_W-1:0] idx;
        logic              dynamic;
        logic              air;
        vec3_t             accel;
        vec3_t             torque;
        logic [INV_W-1:0]  inv;
    } body_t;

    typedef struct packed {
        logic [BODY_W-1:0] idx;
        vec3_t             disp;
        vec3_t             rot;
    } res_t;

    typedef struct packed {
        vec3_t lin;
        vec3_t ang;
    } vel_row_t;

    typedef struct packed {
        logic              en;
        logic [BODY_W-1:0] idx;
        vel_row_t          row;
    } vel_wr_t;

    // Shift right by s, rounding half up.
    function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (x + half) >>> s;
    endfunction

    // Clamp to the signed 32 bit range.
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (x < lo)
        begin
            return 32'sh80000000;
        end
        return x[WORD_W-1:0];
    endfunction

endpackage

>>> hw/rtl/rbes_if.sv
`timescale 1ns / 1ps

// Channel that carries one body step.
interface rbes_body_if;
    import rbes_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [BODY_W-1:0]        body_index;
    logic                     is_dynamic;
    logic                     in_air;
    logic signed [WORD_W-1:0] accel_x;
    logic signed [WORD_W-1:0] accel_y;
    logic signed [WORD_W-1:0] accel_z;
    logic signed [WORD_W-1:0] torque_x;
    logic signed [WORD_W-1:0] torque_y;
    logic signed [WORD_W-1:0] torque_z;
    logic [INV_W-1:0]         inv_inertia;

    modport source (output valid, body_index, is_dynamic, in_air, accel_x, accel_y,
                    accel_z, torque_x, torque_y, torque_z, inv_inertia, input ready);
    modport sink (input valid, body_index, is_dynamic, in_air, accel_x, accel_y,
                  accel_z, torque_x, torque_y, torque_z, inv_inertia, output ready);
endinterface

// Channel that carries one step result.
interface rbes_result_if;
    import rbes_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [BODY_W-1:0]        out_index;
    logic signed [WORD_W-1:0] disp_x;
    logic signed [WORD_W-1:0] disp_y;
    logic signed [WORD_W-1:0] disp_z;
    logic signed [WORD_W-1:0] rot_x;
    logic signed [WORD_W-1:0] rot_y;
    logic signed [WORD_W-1:0] rot_z;

    modport source (output valid, out_index, disp_x, disp_y, disp_z, rot_x, rot_y, rot_z,
                    input ready);
    modport sink (input valid, out_index, disp_x, disp_y, disp_z, rot_x, rot_y, rot_z,
                  output ready);
endinterface

>>> hw/rtl/rbes_vel_store.sv
`timescale 1ns / 1ps

module rbes_vel_store (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  rbes_pkg::vel_wr_t  wr,
    input  logic [rbes_pkg::BODY_W-1:0] raddr,
    output rbes_pkg::vel_row_t rd
);
    import rbes_pkg::*;

    vel_row_t                mem [NUM_BODIES];
    logic [NUM_BODIES-1:0]   vld_reg;
    vel_row_t                rd_data_reg;
    logic                    rd_ok_reg;

    // One row per body; a row never written reads as zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= mem[raddr];
            if (wr.en)
            begin
                mem[wr.idx] <= wr.row;
            end
        end
    end

    // Written flags, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else if (en)
        begin
            rd_ok_reg <= vld_reg[raddr];
            if (wr.en)
            begin
                vld_reg[wr.idx] <= 1'b1;
            end
        end
    end

    assign rd = rd_ok_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/rbes_core.sv
`timescale 1ns / 1ps

module rbes_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            take,
    input  rbes_pkg::body_t item,
    input  rbes_pkg::cfg_t  cfg,
    output logic            res_valid,
    output rbes_pkg::res_t  res
);
    import rbes_pkg::*;

    logic signed [DT_W:0]   dt_s;
    logic signed [DRAG_W:0] drag_s;

    // Stage valid bits.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic s1_valid_next;

    // Index and drag select travel with the item.
    logic [BODY_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [BODY_W-1:0] s5_idx_reg, s6_idx_reg, s7_idx_reg;
    logic s1_air_reg, s2_air_reg, s3_air_reg, s4_air_reg;

    logic signed [WORD_W-1:0] s1_a_next   [3];
    logic signed [WORD_W-1:0] s1_a_reg    [3];
    logic signed [WORD_W-1:0] s1_t_reg    [3];
    logic [INV_W-1:0]         s1_inv_reg;

    logic signed [49:0] s2_padt_next [3];
    logic signed [49:0] s2_padt_reg  [3];
    logic signed [63:0] s2_palp_next [3];
    logic signed [63:0] s2_palp_reg  [3];

    logic signed [33:0]       s3_adt_next [3];
    logic signed [33:0]       s3_adt_reg  [3];
    logic signed [WORD_W-1:0] s3_alp_next [3];
    logic signed [WORD_W-1:0] s3_alp_reg  [3];

    logic signed [52:0] s4_phalf_next [3];
    logic signed [52:0] s4_phalf_reg  [3];
    logic signed [50:0] s4_pwdt_next  [3];
    logic signed [50:0] s4_pwdt_reg   [3];
    logic signed [33:0] s4_adt_reg    [3];

    logic signed [WORD_W-1:0] s5_v_next    [3];
    logic signed [WORD_W-1:0] s5_v_reg     [3];
    logic signed [WORD_W-1:0] s5_w_next    [3];
    logic signed [WORD_W-1:0] s5_w_reg     [3];
    logic signed [35:0]       s5_half_next [3];
    logic signed [35:0]       s5_half_reg  [3];

    logic signed [50:0] s6_pv_next   [3];
    logic signed [50:0] s6_pv_reg    [3];
    logic signed [50:0] s6_pw_next   [3];
    logic signed [50:0] s6_pw_reg    [3];
    logic signed [35:0] s6_half_reg  [3];

    vec3_t s7_disp_next, s7_disp_reg, s7_rot_next, s7_rot_reg;

    // Velocity store and the bypass for a write landing with the read.
    vel_wr_t  wr;
    vel_row_t rd_row;
    vel_row_t old_row;
    vel_row_t fwd_row_reg;
    logic     fwd_reg;
    logic     fwd_next;

    rbes_vel_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .wr    (wr),
        .raddr (s3_idx_reg),
        .rd    (rd_row)
    );

    assign dt_s   = $signed({1'b0, cfg.time_step});
    assign drag_s = $signed({1'b0, (s4_air_reg ? cfg.drag_air : cfg.drag_ground)});

    assign s1_valid_next = take && item.dynamic && (int'(item.idx) < NUM_BODIES);
    assign fwd_next      = s4_valid_reg && (s4_idx_reg == s3_idx_reg);
    assign old_row       = fwd_reg ? fwd_row_reg : rd_row;

    // Datapath of every stage, one lane per axis.
    always_comb
    begin
        logic signed [63:0] sum;
        for (int k = 0; k < 3; k++)
        begin
            // Gravity enters on the y axis only.
            if (k == 1)
            begin
                sum          = $signed(item.accel[k]) + cfg.gravity_y;
                s1_a_next[k] = sat32(sum);
            end
            else
            begin
                s1_a_next[k] = $signed(item.accel[k]);
            end

            s2_padt_next[k] = s1_a_reg[k] * dt_s;
            s2_palp_next[k] = s1_t_reg[k] * $signed({1'b0, s1_inv_reg});

            sum            = rnd(s2_padt_reg[k], FRAC_BITS);
            s3_adt_next[k] = sum[33:0];
            s3_alp_next[k] = sat32(rnd(s2_palp_reg[k], FRAC_BITS));

            s4_phalf_next[k] = s3_adt_reg[k] * dt_s;
            s4_pwdt_next[k]  = s3_alp_reg[k] * dt_s;

            // Velocity update and drag, closed against the store.
            sum             = rnd(s4_phalf_reg[k], FRAC_BITS + 1);
            s5_half_next[k] = sum[35:0];
            sum             = $signed(old_row.lin[k]) + s4_adt_reg[k];
            sum             = sat32(sum) * drag_s;
            s5_v_next[k]    = sat32(rnd(sum, FRAC_BITS));
            sum             = $signed(old_row.ang[k]) + rnd(s4_pwdt_reg[k], FRAC_BITS);
            sum             = sat32(sum) * drag_s;
            s5_w_next[k]    = sat32(rnd(sum, FRAC_BITS));

            s6_pv_next[k] = s5_v_reg[k] * dt_s;
            s6_pw_next[k] = s5_w_reg[k] * dt_s;

            sum             = rnd(s6_pv_reg[k], FRAC_BITS) + s6_half_reg[k];
            s7_disp_next[k] = sat32(sum);
            s7_rot_next[k]  = sat32(rnd(s6_pw_reg[k], FRAC_BITS));
        end
    end

    // Write back the new velocities as the item leaves the update stage.
    always_comb
    begin
        wr.en  = s4_valid_reg;
        wr.idx = s4_idx_reg;
        for (int k = 0; k < 3; k++)
        begin
            wr.row.lin[k] = s5_v_next[k];
            wr.row.ang[k] = s5_w_next[k];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            fwd_reg      <= fwd_next;
        end
    end

    // Payload registers; the whole pipeline moves together.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg  <= item.idx;
            s1_air_reg  <= item.air;
            s1_inv_reg  <= item.inv;
            s2_idx_reg  <= s1_idx_reg;
            s2_air_reg  <= s1_air_reg;
            s3_idx_reg  <= s2_idx_reg;
            s3_air_reg  <= s2_air_reg;
            s4_idx_reg  <= s3_idx_reg;
            s4_air_reg  <= s3_air_reg;
            s5_idx_reg  <= s4_idx_reg;
            s6_idx_reg  <= s5_idx_reg;
            s7_idx_reg  <= s6_idx_reg;
            fwd_row_reg <= wr.row;
            s7_disp_reg <= s7_disp_next;
            s7_rot_reg  <= s7_rot_next;
            for (int k = 0; k < 3; k++)
            begin
                s1_a_reg[k]     <= s1_a_next[k];
                s1_t_reg[k]     <= $signed(item.torque[k]);
                s2_padt_reg[k]  <= s2_padt_next[k];
                s2_palp_reg[k]  <= s2_palp_next[k];
                s3_adt_reg[k]   <= s3_adt_next[k];
                s3_alp_reg[k]   <= s3_alp_next[k];
                s4_phalf_reg[k] <= s4_phalf_next[k];
                s4_pwdt_reg[k]  <= s4_pwdt_next[k];
                s4_adt_reg[k]   <= s3_adt_reg[k];
                s5_v_reg[k]     <= s5_v_next[k];
                s5_w_reg[k]     <= s5_w_next[k];
                s5_half_reg[k]  <= s5_half_next[k];
                s6_pv_reg[k]    <= s6_pv_next[k];
                s6_pw_reg[k]    <= s6_pw_next[k];
                s6_half_reg[k]  <= s5_half_reg[k];
            end
        end
    end

    assign res_valid = s7_valid_reg;
    assign res.idx   = s7_idx_reg;
    assign res.disp  = s7_disp_reg;
    assign res.rot   = s7_rot_reg;

endmodule

>>> hw/rtl/rigid_body_euler_step.sv
`timescale 1ns / 1ps

// Fixed point (Q16.16) semi-implicit Euler step for up to 64 rigid bodies. Each
// transfer on the body channel is one frame step of one body; a dynamic body with
// a valid index gives one transfer on the result channel, others give none. The
// block takes one body per cycle for any mix of body indexes while the result
// channel does not stall: the velocity store is read and written in a single
// update stage with a bypass, so repeated steps of the same body follow back to
// back. When the result channel stalls, the whole pipeline holds. Velocities start
// at zero after reset. The user must write the configuration registers through the
// write port only while no step is in flight; the block does not enforce this.
module rigid_body_euler_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rbes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbes_pkg::WORD_W-1:0]    cfg_data,
    rbes_body_if.sink                      body,
    rbes_result_if.source                  result
);
    import rbes_pkg::*;

    cfg_t  cfg_reg;
    body_t item;
    res_t  res;
    logic  res_valid;
    logic  en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step   <= TIME_STEP_RST;
            cfg_reg.gravity_y   <= GRAVITY_Y_RST;
            cfg_reg.drag_air    <= DRAG_AIR_RST;
            cfg_reg.drag_ground <= DRAG_GROUND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TIME_STEP:   cfg_reg.time_step   <= cfg_data[DT_W-1:0];
                CFG_GRAVITY_Y:   cfg_reg.gravity_y   <= $signed(cfg_data);
                CFG_DRAG_AIR:    cfg_reg.drag_air    <= cfg_data[DRAG_W-1:0];
                CFG_DRAG_GROUND: cfg_reg.drag_ground <= cfg_data[DRAG_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or drains.
    assign en         = !res_valid || result.ready;
    assign body.ready = en;

    assign item.idx        = body.body_index;
    assign item.dynamic    = body.is_dynamic;
    assign item.air        = body.in_air;
    assign item.accel[0]   = body.accel_x;
    assign item.accel[1]   = body.accel_y;
    assign item.accel[2]   = body.accel_z;
    assign item.torque[0]  = body.torque_x;
    assign item.torque[1]  = body.torque_y;
    assign item.torque[2]  = body.torque_z;
    assign item.inv        = body.inv_inertia;

    rbes_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .take      (body.valid && en),
        .item      (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign result.valid     = res_valid;
    assign result.out_index = res.idx;
    assign result.disp_x    = res.disp[0];
    assign result.disp_y    = res.disp[1];
    assign result.disp_z    = res.disp[2];
    assign result.rot_x     = res.rot[0];
    assign result.rot_y     = res.rot[1];
    assign result.rot_z     = res.rot[2];

endmodule
